// ===== hw/rtl/cfa_pkg.sv =====
// Shared codes, widths and the pipeline item type of the constant-folding ALU.
package cfa_pkg;

    localparam int unsigned DATA_W    = 64;
    localparam int unsigned DIV_STEPS = DATA_W;

    localparam logic [4:0] OP_ADD    = 5'd0;
    localparam logic [4:0] OP_SUB    = 5'd1;
    localparam logic [4:0] OP_MUL    = 5'd2;
    localparam logic [4:0] OP_DIV    = 5'd3;
    localparam logic [4:0] OP_MOD    = 5'd4;
    localparam logic [4:0] OP_EQ     = 5'd5;
    localparam logic [4:0] OP_NE     = 5'd6;
    localparam logic [4:0] OP_LT     = 5'd7;
    localparam logic [4:0] OP_LE     = 5'd8;
    localparam logic [4:0] OP_GT     = 5'd9;
    localparam logic [4:0] OP_GE     = 5'd10;
    localparam logic [4:0] OP_AND    = 5'd11;
    localparam logic [4:0] OP_OR     = 5'd12;
    localparam logic [4:0] OP_XOR    = 5'd13;
    localparam logic [4:0] OP_SHL    = 5'd14;
    localparam logic [4:0] OP_SHR    = 5'd15;
    localparam logic [4:0] OP_NEG    = 5'd16;
    localparam logic [4:0] OP_BITNOT = 5'd17;
    localparam logic [4:0] OP_LOGNOT = 5'd18;
    localparam logic [4:0] OP_LOGAND = 5'd19;
    localparam logic [4:0] OP_LOGOR  = 5'd20;

    localparam logic [2:0] KIND_INT   = 3'd0;
    localparam logic [2:0] KIND_FLOAT = 3'd1;
    localparam logic [2:0] KIND_BOOL  = 3'd2;
    localparam logic [2:0] KIND_NIL   = 3'd3;
    localparam logic [2:0] KIND_STR   = 3'd4;

    localparam logic [1:0] RKIND_INT   = 2'd0;
    localparam logic [1:0] RKIND_FLOAT = 2'd1;
    localparam logic [1:0] RKIND_BOOL  = 2'd2;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        valid;
        logic        is_div;
        logic        is_mod;
        logic        folded;
        logic [1:0]  kind;
        logic [63:0] value;
        logic        q_neg;
        logic        r_neg;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] dvs;
    } t_item;

endpackage

// ===== hw/rtl/cfa_front.sv =====
// Decode, simple operations and the staged 64-bit multiply of the constant-folding ALU.
module cfa_front
    import cfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [4:0]  i_operation,
    input  logic [2:0]  i_left_kind,
    input  logic [63:0] i_left_value,
    input  logic [2:0]  i_right_kind,
    input  logic [63:0] i_right_value,
    output t_item       o_item
);

    t_item       n_s0, n_s3;
    t_item       r_s0, r_s1, r_s2, r_s3;
    logic        n_mul;
    logic        r_mul0, r_mul1, r_mul2;
    logic [63:0] r_ma0, r_mb0;
    logic [31:0] r_ma1, r_mb1, r_al1, r_bh1;
    logic [63:0] r_p0_1, r_p0_2;
    logic [31:0] r_p1_2, r_p2_2;
    logic [63:0] p0_full, p1_full, p2_full;
    logic [31:0] hi_sum;

    logic [63:0] lv, rv, abs_l, abs_r;
    logic        both_int, both_bool, trap, shift_bad, truth, truth_ok;

    always_comb begin
        lv        = i_left_value;
        rv        = i_right_value;
        both_int  = (i_left_kind == KIND_INT) && (i_right_kind == KIND_INT);
        both_bool = (i_left_kind == KIND_BOOL) && (i_right_kind == KIND_BOOL);
        trap      = (rv == 64'd0) || ((lv == SIGN_BIT) && (rv == '1));
        shift_bad = |rv[63:6];
        abs_l     = lv[63] ? (64'd0 - lv) : lv;
        abs_r     = rv[63] ? (64'd0 - rv) : rv;
        truth_ok  = 1'b1;
        case (i_left_kind)
            KIND_INT:   truth = (lv != 64'd0);
            KIND_FLOAT: truth = ((lv & ~SIGN_BIT) != 64'd0);
            KIND_BOOL:  truth = lv[0];
            KIND_NIL:   truth = 1'b0;
            KIND_STR:   truth = 1'b1;
            default: begin
                truth    = 1'b0;
                truth_ok = 1'b0;
            end
        endcase

        n_s0        = '0;
        n_s0.valid  = i_accept;
        n_s0.q_neg  = lv[63] ^ rv[63];
        n_s0.r_neg  = lv[63];
        n_s0.quo    = abs_l;
        n_s0.dvs    = abs_r;
        n_mul       = 1'b0;
        case (i_operation)
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
                n_s0.folded = both_int;
                n_s0.kind   = RKIND_INT;
                case (i_operation)
                    OP_ADD:  n_s0.value = lv + rv;
                    OP_SUB:  n_s0.value = lv - rv;
                    OP_AND:  n_s0.value = lv & rv;
                    OP_OR:   n_s0.value = lv | rv;
                    default: n_s0.value = lv ^ rv;
                endcase
            end
            OP_MUL: begin
                n_s0.folded = both_int;
                n_mul       = both_int;
            end
            OP_DIV: begin
                n_s0.folded = both_int && !trap;
                n_s0.is_div = both_int && !trap;
            end
            OP_MOD: begin
                n_s0.folded = both_int && !trap;
                n_s0.is_mod = both_int && !trap;
            end
            OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
                n_s0.folded = both_int;
                n_s0.kind   = RKIND_BOOL;
                case (i_operation)
                    OP_EQ:   n_s0.value[0] = (lv == rv);
                    OP_NE:   n_s0.value[0] = (lv != rv);
                    OP_LT:   n_s0.value[0] = ($signed(lv) <  $signed(rv));
                    OP_LE:   n_s0.value[0] = ($signed(lv) <= $signed(rv));
                    OP_GT:   n_s0.value[0] = ($signed(lv) >  $signed(rv));
                    default: n_s0.value[0] = ($signed(lv) >= $signed(rv));
                endcase
            end
            OP_SHL: begin
                n_s0.folded = both_int && !shift_bad;
                n_s0.kind   = RKIND_INT;
                n_s0.value  = lv << rv[5:0];
            end
            OP_SHR: begin
                n_s0.folded = both_int && !shift_bad;
                n_s0.kind   = RKIND_INT;
                n_s0.value  = lv >> rv[5:0];
            end
            OP_NEG: begin
                if (i_left_kind == KIND_INT) begin
                    n_s0.folded = 1'b1;
                    n_s0.kind   = RKIND_INT;
                    n_s0.value  = 64'd0 - lv;
                end else if (i_left_kind == KIND_FLOAT) begin
                    n_s0.folded = 1'b1;
                    n_s0.kind   = RKIND_FLOAT;
                    n_s0.value  = lv ^ SIGN_BIT;
                end
            end
            OP_BITNOT: begin
                n_s0.folded = (i_left_kind == KIND_INT);
                n_s0.kind   = RKIND_INT;
                n_s0.value  = ~lv;
            end
            OP_LOGNOT: begin
                n_s0.folded   = truth_ok;
                n_s0.kind     = RKIND_BOOL;
                n_s0.value[0] = !truth;
            end
            OP_LOGAND: begin
                n_s0.folded   = both_bool;
                n_s0.kind     = RKIND_BOOL;
                n_s0.value[0] = lv[0] & rv[0];
            end
            OP_LOGOR: begin
                n_s0.folded   = both_bool;
                n_s0.kind     = RKIND_BOOL;
                n_s0.value[0] = lv[0] | rv[0];
            end
            default: n_s0.folded = 1'b0;
        endcase
        if (!n_s0.folded) begin
            n_s0.kind  = RKIND_INT;
            n_s0.value = 64'd0;
        end
    end

    always_comb begin
        p0_full = {32'd0, r_ma0[31:0]} * {32'd0, r_mb0[31:0]};
        p1_full = {32'd0, r_ma1} * {32'd0, r_mb1};
        p2_full = {32'd0, r_al1} * {32'd0, r_bh1};
        hi_sum  = r_p1_2 + r_p2_2;
        n_s3    = r_s2;
        if (r_mul2) begin
            n_s3.value = r_p0_2 + {hi_sum, 32'd0};
            n_s3.kind  = RKIND_INT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else begin
            r_s0 <= n_s0;
            r_s1 <= r_s0;
            r_s2 <= r_s1;
            r_s3 <= n_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul0 <= n_mul;
        r_ma0  <= i_left_value;
        r_mb0  <= i_right_value;
        r_mul1 <= r_mul0;
        r_p0_1 <= p0_full;
        r_ma1  <= r_ma0[63:32];
        r_mb1  <= r_mb0[31:0];
        r_al1  <= r_ma0[31:0];
        r_bh1  <= r_mb0[63:32];
        r_mul2 <= r_mul1;
        r_p0_2 <= r_p0_1;
        r_p1_2 <= p1_full[31:0];
        r_p2_2 <= p2_full[31:0];
    end

    assign o_item = r_s3;

endmodule

// ===== hw/rtl/cfa_cell.sv =====
// One restoring-division step cell of the divider chain; carries the whole item along.
module cfa_cell
    import cfa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_item,
    output t_item o_item
);

    t_item       r_item;
    t_item       n_item;
    logic [64:0] shifted, trial;

    always_comb begin
        shifted = {i_item.rem, i_item.quo[63]};
        trial   = shifted - {1'b0, i_item.dvs};
        n_item  = i_item;
        if (!trial[64]) begin
            n_item.rem = trial[63:0];
            n_item.quo = {i_item.quo[62:0], 1'b1};
        end else begin
            n_item.rem = shifted[63:0];
            n_item.quo = {i_item.quo[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== hw/rtl/constant_fold_alu.sv =====
// Top level of the constant-folding ALU: front stages, divider cell chain and result register.
// Usage:
//   Command channel: drive the operation and both tagged operands with start high;
//   the command transfers at a rising edge where start is high and busy is low.
//   busy stays low, so a new command may transfer in every cycle.
//   Result channel: o_valid is high for exactly one cycle with o_folded,
//   o_result_kind and o_result_value; the receiver cannot stall and must take it.
//   An unfolded result carries kind and value zero.
// Path: a command passes four front stages (decode and the three-step 32-bit
//   multiply), 64 division cells of one quotient bit each, one output register.
// Throughput: one command per cycle, every operation takes the same path through
//   the same stages, so results leave in command order.
// Reset: synchronous active-low i_rst_n drops every in-flight command; no
//   result strobes until new commands pass through the pipeline.
module constant_fold_alu
    import cfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  i_operation,
    input  logic [2:0]  i_left_kind,
    input  logic [63:0] i_left_value,
    input  logic [2:0]  i_right_kind,
    input  logic [63:0] i_right_value,
    output logic        o_valid,
    output logic        o_folded,
    output logic [1:0]  o_result_kind,
    output logic [63:0] o_result_value
);

    t_item       chain [0:DIV_STEPS];
    t_item       last;
    logic [63:0] quo_s, rem_s, n_value;
    logic        r_valid, r_folded;
    logic [1:0]  r_kind;
    logic [63:0] r_value;

    assign busy = 1'b0;

    cfa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (start && !busy),
        .i_operation   (i_operation),
        .i_left_kind   (i_left_kind),
        .i_left_value  (i_left_value),
        .i_right_kind  (i_right_kind),
        .i_right_value (i_right_value),
        .o_item        (chain[0])
    );

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        cfa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (chain[k]),
            .o_item  (chain[k+1])
        );
    end

    always_comb begin
        last  = chain[DIV_STEPS];
        quo_s = last.q_neg ? (64'd0 - last.quo) : last.quo;
        rem_s = last.r_neg ? (64'd0 - last.rem) : last.rem;
        if (last.is_div) begin
            n_value = quo_s;
        end else if (last.is_mod) begin
            n_value = rem_s;
        end else begin
            n_value = last.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= last.valid;
        end
        r_folded <= last.folded;
        r_kind   <= last.kind;
        r_value  <= n_value;
    end

    assign o_valid        = r_valid;
    assign o_folded       = r_folded;
    assign o_result_kind  = r_kind;
    assign o_result_value = r_value;

    a_unfolded_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_folded) |-> (o_result_kind == RKIND_INT && o_result_value == 64'd0))
        else $error("unfolded result carries nonzero payload");

    a_bool_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_folded && o_result_kind == RKIND_BOOL) |-> (o_result_value[63:1] == 63'd0))
        else $error("boolean result wider than one bit");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_folded) |-> (o_result_kind != 2'd3))
        else $error("folded result with undefined kind");

    a_divmod_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last.valid |-> !(last.is_div && last.is_mod))
        else $error("item marked both divide and modulo");

endmodule

// ===== test/constant_fold_alu_tb.sv =====
// Self-checking testbench of the constant-folding ALU: directed table, then random commands.
`timescale 1ns / 1ps

module constant_fold_alu_tb;
    import cfa_pkg::*;

    localparam int LATENCY   = 69;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1900;

    typedef struct packed {
        logic        folded;
        logic [1:0]  kind;
        logic [63:0] value;
    } t_fold;

    typedef struct {
        logic [4:0]  op;
        logic [2:0]  lk;
        logic [63:0] lv;
        logic [2:0]  rk;
        logic [63:0] rv;
        bit          typed;
        t_fold       res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [4:0]  i_operation = '0;
    logic [2:0]  i_left_kind = '0;
    logic [63:0] i_left_value = '0;
    logic [2:0]  i_right_kind = '0;
    logic [63:0] i_right_value = '0;
    logic        o_valid;
    logic        o_folded;
    logic [1:0]  o_result_kind;
    logic [63:0] o_result_value;

    t_fold fold_q[$];
    int    errors = 0;
    int    idle_cycles = 0;
    bit    done = 0;

    constant_fold_alu u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_fold nofold();
        return '{1'b0, 2'd0, 64'd0};
    endfunction

    function automatic t_fold fold_of(logic [4:0] op, logic [2:0] lk, logic [63:0] lv,
                                      logic [2:0] rk, logic [63:0] rv);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic               t;
        x = lv;
        y = rv;
        if (op <= OP_SHR) begin
            if (lk != KIND_INT || rk != KIND_INT) return nofold();
            case (op)
                OP_ADD: return '{1'b1, RKIND_INT, lv + rv};
                OP_SUB: return '{1'b1, RKIND_INT, lv - rv};
                OP_MUL: return '{1'b1, RKIND_INT, lv * rv};
                OP_DIV, OP_MOD: begin
                    if (rv == 0 || (lv == SIGN_BIT && rv == '1)) return nofold();
                    if (op == OP_DIV) return '{1'b1, RKIND_INT, x / y};
                    return '{1'b1, RKIND_INT, x % y};
                end
                OP_EQ:  return '{1'b1, RKIND_BOOL, {63'd0, x == y}};
                OP_NE:  return '{1'b1, RKIND_BOOL, {63'd0, x != y}};
                OP_LT:  return '{1'b1, RKIND_BOOL, {63'd0, x < y}};
                OP_LE:  return '{1'b1, RKIND_BOOL, {63'd0, x <= y}};
                OP_GT:  return '{1'b1, RKIND_BOOL, {63'd0, x > y}};
                OP_GE:  return '{1'b1, RKIND_BOOL, {63'd0, x >= y}};
                OP_AND: return '{1'b1, RKIND_INT, lv & rv};
                OP_OR:  return '{1'b1, RKIND_INT, lv | rv};
                OP_XOR: return '{1'b1, RKIND_INT, lv ^ rv};
                default: begin
                    if (rv >= 64) return nofold();
                    if (op == OP_SHL) return '{1'b1, RKIND_INT, lv << rv[5:0]};
                    return '{1'b1, RKIND_INT, lv >> rv[5:0]};
                end
            endcase
        end
        case (op)
            OP_NEG: begin
                if (lk == KIND_INT) return '{1'b1, RKIND_INT, -lv};
                if (lk == KIND_FLOAT) return '{1'b1, RKIND_FLOAT, lv ^ SIGN_BIT};
                return nofold();
            end
            OP_BITNOT: begin
                if (lk == KIND_INT) return '{1'b1, RKIND_INT, ~lv};
                return nofold();
            end
            OP_LOGNOT: begin
                case (lk)
                    KIND_INT:   t = lv != 0;
                    KIND_FLOAT: t = (lv & ~SIGN_BIT) != 0;
                    KIND_BOOL:  t = lv[0];
                    KIND_NIL:   t = 1'b0;
                    KIND_STR:   t = 1'b1;
                    default:    return nofold();
                endcase
                return '{1'b1, RKIND_BOOL, {63'd0, !t}};
            end
            OP_LOGAND, OP_LOGOR: begin
                if (lk != KIND_BOOL || rk != KIND_BOOL) return nofold();
                if (op == OP_LOGAND) return '{1'b1, RKIND_BOOL, {63'd0, lv[0] & rv[0]}};
                return '{1'b1, RKIND_BOOL, {63'd0, lv[0] | rv[0]}};
            end
            default: return nofold();
        endcase
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 9))
            0: return SIGN_BIT;
            1: return ~SIGN_BIT;
            2: return '1;
            3: return 64'd0;
            4: return 64'($urandom_range(0, 70));
            5: return -64'($urandom_range(1, 5));
            6: return {32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [2:0] rand_kind(logic [2:0] pref);
        if ($urandom_range(0, 3) != 0) return pref;
        return 3'($urandom());
    endfunction

    task automatic hold_off();
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) start <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic send(t_row r);
        start         <= 1'b1;
        i_operation   <= r.op;
        i_left_kind   <= r.lk;
        i_left_value  <= r.lv;
        i_right_kind  <= r.rk;
        i_right_value <= r.rv;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        fold_q.push_back(r.typed ? r.res : fold_of(r.op, r.lk, r.lv, r.rk, r.rv));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (fold_q.size() == 0) begin
                $display("%0t: unexpected result %b/%0d/%h", $time, o_folded,
                         o_result_kind, o_result_value);
                errors++;
            end else begin
                t_fold e;
                e = fold_q.pop_front();
                if (e.folded !== o_folded) begin
                    $display("%0t: folded exp %b act %b", $time, e.folded, o_folded);
                    errors++;
                end
                if (e.kind !== o_result_kind) begin
                    $display("%0t: kind exp %0d act %0d", $time, e.kind, o_result_kind);
                    errors++;
                end
                if (e.value !== o_result_value) begin
                    $display("%0t: value exp %h act %h", $time, e.value, o_result_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (!done && idle_cycles >= WDOG_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_row dir[$];
        t_row r;
        logic [4:0] op;
        logic [2:0] pk;
        dir.push_back('{OP_ADD, KIND_INT, ~SIGN_BIT, KIND_INT, 64'd1, 1, '{1'b1, RKIND_INT, SIGN_BIT}});
        dir.push_back('{OP_SUB, KIND_INT, SIGN_BIT, KIND_INT, 64'd1, 1, '{1'b1, RKIND_INT, ~SIGN_BIT}});
        dir.push_back('{OP_MUL, KIND_INT, '1, KIND_INT, '1, 1, '{1'b1, RKIND_INT, 64'd1}});
        dir.push_back('{OP_DIV, KIND_INT, 64'd7, KIND_INT, 64'd0, 1, nofold()});
        dir.push_back('{OP_MOD, KIND_INT, SIGN_BIT, KIND_INT, '1, 1, nofold()});
        dir.push_back('{OP_DIV, KIND_INT, SIGN_BIT, KIND_INT, '1, 1, nofold()});
        dir.push_back('{OP_DIV, KIND_INT, -64'd7, KIND_INT, 64'd2, 0, '0});
        dir.push_back('{OP_MOD, KIND_INT, -64'd7, KIND_INT, 64'd2, 0, '0});
        dir.push_back('{OP_EQ, KIND_INT, '1, KIND_INT, '1, 1, '{1'b1, RKIND_BOOL, 64'd1}});
        dir.push_back('{OP_NE, KIND_INT, 64'd0, KIND_INT, 64'd0, 1, '{1'b1, RKIND_BOOL, 64'd0}});
        dir.push_back('{OP_LT, KIND_INT, SIGN_BIT, KIND_INT, 64'd0, 1, '{1'b1, RKIND_BOOL, 64'd1}});
        dir.push_back('{OP_LE, KIND_FLOAT, 64'd0, KIND_INT, 64'd0, 1, nofold()});
        dir.push_back('{OP_GT, KIND_INT, 64'd1, KIND_BOOL, 64'd0, 1, nofold()});
        dir.push_back('{OP_GE, KIND_INT, ~SIGN_BIT, KIND_INT, SIGN_BIT, 1, '{1'b1, RKIND_BOOL, 64'd1}});
        dir.push_back('{OP_AND, KIND_INT, '1, KIND_INT, SIGN_BIT, 1, '{1'b1, RKIND_INT, SIGN_BIT}});
        dir.push_back('{OP_XOR, KIND_INT, '1, KIND_INT, '1, 1, '{1'b1, RKIND_INT, 64'd0}});
        dir.push_back('{OP_SHL, KIND_INT, 64'd1, KIND_INT, 64'd63, 1, '{1'b1, RKIND_INT, SIGN_BIT}});
        dir.push_back('{OP_SHR, KIND_INT, '1, KIND_INT, 64'd64, 1, nofold()});
        dir.push_back('{OP_SHL, KIND_INT, 64'd1, KIND_INT, '1, 1, nofold()});
        dir.push_back('{OP_NEG, KIND_FLOAT, 64'd0, KIND_NIL, 64'd0, 1, '{1'b1, RKIND_FLOAT, SIGN_BIT}});
        dir.push_back('{OP_BITNOT, KIND_BOOL, 64'd1, KIND_INT, 64'd0, 1, nofold()});
        dir.push_back('{OP_LOGNOT, KIND_FLOAT, SIGN_BIT, KIND_INT, 64'd0, 1, '{1'b1, RKIND_BOOL, 64'd1}});
        dir.push_back('{OP_LOGNOT, KIND_STR, 64'd0, KIND_INT, 64'd0, 1, '{1'b1, RKIND_BOOL, 64'd0}});
        dir.push_back('{OP_LOGNOT, 3'd7, 64'd0, KIND_INT, 64'd0, 1, nofold()});
        dir.push_back('{OP_LOGAND, KIND_BOOL, '1, KIND_BOOL, 64'd3, 1, '{1'b1, RKIND_BOOL, 64'd1}});
        dir.push_back('{5'd31, KIND_INT, 64'd1, KIND_INT, 64'd1, 1, nofold()});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir[i]) begin
            send(dir[i]);
            hold_off();
        end
        // drain once before the random part
        start <= 1'b0;
        while (fold_q.size() != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            op = ($urandom_range(0, 19) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 20));
            pk = (op == OP_LOGAND || op == OP_LOGOR) ? KIND_BOOL :
                 (op == OP_NEG || op == OP_LOGNOT) ? 3'($urandom_range(0, 5)) : KIND_INT;
            r.op = op;
            r.lk = rand_kind(pk);
            r.lv = rand_value();
            r.rk = rand_kind(pk);
            r.rv = rand_value();
            r.typed = 0;
            r.res = '0;
            send(r);
            hold_off();
        end

        start <= 1'b0;
        while (fold_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        done = 1;
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
